// ===== sv/b2y420_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2y420_pkg
// Shared types, register indexes and conversion constants for the BGR to
// Y'CbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package b2y420_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned WIDTH_W       = 12;
  localparam int unsigned HEIGHT_W      = 13;
  localparam int unsigned ROW_W         = 12;
  localparam int unsigned ROWS_MAX      = 4096;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SUM_W         = 18;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_HALF_SCALE = 2'd2
  } cfg_reg_e;

  localparam logic [SUM_W-1:0] Y_R     = 18'd306;
  localparam logic [SUM_W-1:0] Y_G     = 18'd601;
  localparam logic [SUM_W-1:0] Y_B     = 18'd117;
  localparam logic [SUM_W-1:0] CB_R    = 18'd173;
  localparam logic [SUM_W-1:0] CB_G    = 18'd339;
  localparam logic [SUM_W-1:0] CB_B    = 18'd512;
  localparam logic [SUM_W-1:0] CR_R    = 18'd512;
  localparam logic [SUM_W-1:0] CR_G    = 18'd429;
  localparam logic [SUM_W-1:0] CR_B    = 18'd83;
  localparam logic [SUM_W-1:0] C_OFFS  = 18'd131072;  // 128 << 10

  // blue [7:0], green [15:8], red [23:16]
  typedef logic [23:0] pix_t;

  typedef struct packed {
    logic half;
    logic lv;
    logic cv;
    logic fe;
  } flags_t;

  typedef struct packed {
    pix_t ul;
    pix_t up;
    pix_t left;
    pix_t cur;
  } window_t;

  typedef struct packed {
    logic       fe;
    logic       cv;
    logic       lv;
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] luma;
  } res_t;

  function automatic pix_t avg4(pix_t a, pix_t b, pix_t c, pix_t d);
    pix_t       r;
    logic [9:0] s;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      s = 10'(a[8*k +: 8]) + 10'(b[8*k +: 8]) + 10'(c[8*k +: 8]) + 10'(d[8*k +: 8]);
      r[8*k +: 8] = s[9:2];
    end
    return r;
  endfunction

endpackage

// ===== sv/b2y420_lbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2y420_lbuf
// Line store of the previous source row with the 2x2 pixel neighborhood.
// ----------------------------------------------------------------------------
module b2y420_lbuf
  import b2y420_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [CW-1:0] addr_i,
  input  pix_t          pix_i,
  output window_t       win_o
);

  pix_t mem [MAX_WIDTH];
  pix_t rd_q;
  pix_t cur_q;
  pix_t left_q;
  pix_t ul_q;

  // read-first: same entry is read and overwritten on one edge
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q         <= mem[addr_i];
      mem[addr_i]  <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cur_q  <= pix_i;
      left_q <= cur_q;
      ul_q   <= rd_q;
    end
  end

  assign win_o = '{ul: ul_q, up: rd_q, left: left_q, cur: cur_q};

endmodule

// ===== sv/b2y420_csc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2y420_csc
// Averaging and fixed-point BT.601 color conversion, two register stages.
// ----------------------------------------------------------------------------
module b2y420_csc
  import b2y420_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  flags_t     flags_i,
  input  window_t    win_i,
  output logic       valid_o,
  output res_t       res_o,
  output logic [1:0] busy_o
);

  logic   v2_q, v3_q;
  flags_t flags2_q, flags3_q;
  pix_t   ypix_q, cpix_q;
  pix_t   avg;
  logic [SUM_W-1:0] ysum_d, cbs_d, crs_d;
  logic [SUM_W-1:0] ysum_q, cbs_q, crs_q;
  logic [SUM_W-1:0] yb, yg, yr, cb_b, cb_g, cb_r;
  logic [7:0] cbq;

  assign avg = avg4(win_i.ul, win_i.up, win_i.left, win_i.cur);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    flags2_q <= flags_i;
    ypix_q   <= flags_i.half ? avg : win_i.cur;
    cpix_q   <= avg;
  end

  assign yb = SUM_W'(ypix_q[7:0]);
  assign yg = SUM_W'(ypix_q[15:8]);
  assign yr = SUM_W'(ypix_q[23:16]);
  assign cb_b = SUM_W'(cpix_q[7:0]);
  assign cb_g = SUM_W'(cpix_q[15:8]);
  assign cb_r = SUM_W'(cpix_q[23:16]);

  assign ysum_d = Y_R * yr + Y_G * yg + Y_B * yb;
  assign cbs_d  = C_OFFS + CB_R * cb_r + CB_G * cb_g - CB_B * cb_b;
  assign crs_d  = C_OFFS + CR_R * cb_r - CR_G * cb_g - CR_B * cb_b;

  always_ff @(posedge clk_i) begin
    flags3_q <= flags2_q;
    ysum_q   <= ysum_d;
    cbs_q    <= cbs_d;
    crs_q    <= crs_d;
  end

  assign cbq = cbs_q[SUM_W-1:10];

  always_comb begin
    res_o.fe   = flags3_q.fe;
    res_o.lv   = flags3_q.lv;
    res_o.cv   = flags3_q.cv;
    res_o.luma = flags3_q.lv ? ysum_q[SUM_W-1:10] : 8'd0;
    res_o.cb   = 8'd0;
    res_o.cr   = 8'd0;
    if (flags3_q.cv) begin
      res_o.cb = (cbq == 8'd0) ? 8'hFF : 8'(~cbq + 8'd1);
      res_o.cr = crs_q[SUM_W-1:10];
    end
  end

  assign valid_o = v3_q;
  assign busy_o  = 2'(v2_q) + 2'(v3_q);

endmodule

// ===== sv/b2y420_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2y420_fifo
// Result queue driving the master stream side.
// ----------------------------------------------------------------------------
module b2y420_fifo
  import b2y420_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  res_t                  res_i,
  output logic [FIFO_CNT_W-1:0] count_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output res_t                  res_o
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  res_t                  buf_q [FIFO_DEPTH];
  logic [PW-1:0]         wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  pop;

  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= res_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign res_o   = buf_q[rd_q];
  assign count_o = cnt_q;

endmodule

// ===== sv/bgr_to_ycbcr420_converter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_ycbcr420_converter_core
// BGR raster stream to full-range BT.601 Y'CbCr 4:2:0, full or half size.
// Path: flags1_q, the converter stages, then the result queue. Throughput:
// one item per cycle while s_axis_tready is high; the line store does one
// read and one write per item on its single port, and an 8-entry result
// queue absorbs stalls. Reset: counters cleared, queue empty, registers at
// 640 x 480 full size; line store contents are not cleared.
// ----------------------------------------------------------------------------
module bgr_to_ycbcr420_converter_core
  import b2y420_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,   // blue, green, red
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,   // luma, cb, cr
  output logic [1:0]            m_axis_tuser,   // luma_valid, chroma_valid
  output logic                  m_axis_tlast,   // frame_end
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WCMP  = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam int unsigned OCC_W = $clog2(FIFO_DEPTH + 4);

  logic [WIDTH_W-1:0]  src_width_q;
  logic [HEIGHT_W-1:0] src_height_q;
  logic                half_q;
  logic [CW-1:0]       col_q;
  logic [ROW_W-1:0]    row_q;
  logic                v1_q;
  flags_t              flags1_q;

  logic                acc;
  logic [WCMP-1:0]     w_eff, usew, col_x;
  logic [HEIGHT_W-1:0] h_eff, useh, row_x;
  logic                last_col, last_row, in_area;
  flags_t              flags;
  window_t             win;
  logic                csc_valid;
  res_t                csc_res, out_res;
  logic [1:0]          csc_busy;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic [OCC_W-1:0]    occ;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= WIDTH_W'(640);
      src_height_q <= HEIGHT_W'(480);
      half_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i;
        REG_HALF_SCALE: half_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_width_q == '0) begin
      w_eff = WCMP'(1);
    end else if (WCMP'(src_width_q) > WCMP'(MAX_WIDTH)) begin
      w_eff = WCMP'(MAX_WIDTH);
    end else begin
      w_eff = WCMP'(src_width_q);
    end
    if (src_height_q == '0) begin
      h_eff = HEIGHT_W'(1);
    end else if (src_height_q > HEIGHT_W'(ROWS_MAX)) begin
      h_eff = HEIGHT_W'(ROWS_MAX);
    end else begin
      h_eff = src_height_q;
    end
    col_x = WCMP'(col_q);
    row_x = HEIGHT_W'(row_q);
    if (half_q) begin
      usew = {w_eff[WCMP-1:2], 2'b00};
      useh = {h_eff[HEIGHT_W-1:2], 2'b00};
    end else begin
      usew = {w_eff[WCMP-1:1], 1'b0};
      useh = {h_eff[HEIGHT_W-1:1], 1'b0};
    end
    in_area  = (col_x < usew) && (row_x < useh);
    last_col = (col_x + 1'b1) >= w_eff;
    last_row = (row_x + 1'b1) >= h_eff;
    flags.half = half_q;
    flags.fe   = last_col && last_row;
    if (half_q) begin
      flags.lv = in_area && col_q[0] && row_q[0];
      flags.cv = in_area && (col_q[1:0] == 2'b10) && (row_q[1:0] == 2'b10);
    end else begin
      flags.lv = in_area;
      flags.cv = in_area && col_q[0] && row_q[0];
    end
  end

  assign occ           = OCC_W'(fifo_cnt) + OCC_W'(v1_q) + OCC_W'(csc_busy);
  assign s_axis_tready = occ < OCC_W'(FIFO_DEPTH);
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      v1_q <= acc && (flags.lv || flags.cv || flags.fe);
      if (acc) begin
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      flags1_q <= flags;
    end
  end

  b2y420_lbuf #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_lbuf (
    .clk_i  (clk_i),
    .en_i   (acc),
    .addr_i (col_q),
    .pix_i  (s_axis_tdata),
    .win_o  (win)
  );

  b2y420_csc u_csc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .flags_i (flags1_q),
    .win_i   (win),
    .valid_o (csc_valid),
    .res_o   (csc_res),
    .busy_o  (csc_busy)
  );

  b2y420_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (csc_valid),
    .res_i   (csc_res),
    .count_o (fifo_cnt),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {out_res.cr, out_res.cb, out_res.luma};
  assign m_axis_tuser = {out_res.cv, out_res.lv};
  assign m_axis_tlast = out_res.fe;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_W'(FIFO_DEPTH))
    else $error("result queue credit exceeded");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && flags.fe |=> (col_q == '0) && (row_q == '0))
    else $error("counters not cleared after last pixel of frame");

  a_half_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && half_q && flags.cv |-> !flags.lv)
    else $error("half size chroma site coincides with luma site");

endmodule
